>>> src/wqm_pkg.sv
// Shared types, constants and a helper function for the word query matcher.
package wqm_pkg;

	// Longest query that can match
	localparam int unsigned QUERY_MAX = 32;
	// Lines per page after reset
	localparam logic [15:0] RESET_LINES_PER_PAGE = 16'd50;
	// Smallest page size that takes effect
	localparam logic [15:0] MIN_LINES_PER_PAGE = 16'd2;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [5:0] LETTER_POS_MAX = 6'd63;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_QUERY_LENGTH = 3'd0;
	localparam logic [2:0] REG_QUERY_LO = 3'd1;
	localparam logic [2:0] REG_QUERY_MID_LO = 3'd2;
	localparam logic [2:0] REG_QUERY_MID_HI = 3'd3;
	localparam logic [2:0] REG_QUERY_HI = 3'd4;
	localparam logic [2:0] REG_LINES_PER_PAGE = 3'd5;

	// Configuration as seen by the front end
	typedef struct packed {
		logic [5:0]   query_length;
		logic [255:0] query_chars;
		logic [15:0]  lines_per_page;
	} wqm_cfg_t;

	// One classified event passed from front to back
	typedef struct packed {
		logic        is_match;
		logic        is_final;
		logic        word_present;
		logic [31:0] page_number;
	} wqm_event_t;

	// Increment that stops at all ones
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == SAT32) ? v : v + 32'd1;
	endfunction

endpackage

>>> src/wqm_regs.sv
// APB configuration registers of the word query matcher.
module wqm_regs
	import wqm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output wqm_cfg_t    cfg
);

	logic [5:0]  query_length_q;
	logic [63:0] query_lo_q;
	logic [63:0] query_mid_lo_q;
	logic [63:0] query_mid_hi_q;
	logic [63:0] query_hi_q;
	logic [15:0] lines_per_page_q;
	logic        wr_en;
	logic [2:0]  reg_index;

	assign pready    = 1'b1;
	assign wr_en     = psel & penable & pwrite;
	assign reg_index = paddr[5:3];

	// Write the addressed register; drop writes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q   <= 6'd0;
			query_lo_q       <= 64'd0;
			query_mid_lo_q   <= 64'd0;
			query_mid_hi_q   <= 64'd0;
			query_hi_q       <= 64'd0;
			lines_per_page_q <= RESET_LINES_PER_PAGE;
		end else if (wr_en) begin
			unique case (reg_index)
				REG_QUERY_LENGTH:   query_length_q   <= pwdata[5:0];
				REG_QUERY_LO:       query_lo_q       <= pwdata;
				REG_QUERY_MID_LO:   query_mid_lo_q   <= pwdata;
				REG_QUERY_MID_HI:   query_mid_hi_q   <= pwdata;
				REG_QUERY_HI:       query_hi_q       <= pwdata;
				REG_LINES_PER_PAGE: lines_per_page_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_index)
			REG_QUERY_LENGTH:   prdata = {58'd0, query_length_q};
			REG_QUERY_LO:       prdata = query_lo_q;
			REG_QUERY_MID_LO:   prdata = query_mid_lo_q;
			REG_QUERY_MID_HI:   prdata = query_mid_hi_q;
			REG_QUERY_HI:       prdata = query_hi_q;
			REG_LINES_PER_PAGE: prdata = {48'd0, lines_per_page_q};
			default:            prdata = 64'd0;
		endcase
	end

	assign cfg.query_length   = query_length_q;
	assign cfg.query_chars    = {query_hi_q, query_mid_hi_q, query_mid_lo_q, query_lo_q};
	assign cfg.lines_per_page = lines_per_page_q;

endmodule

>>> src/wqm_front.sv
// Front end: takes text items, tracks word, letter prefix, line and page, emits events.
module wqm_front
	import wqm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  wqm_cfg_t   cfg,
	input  logic       in_valid,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       in_ready,
	output logic       ev_push,
	output wqm_event_t ev,
	input  logic       ev_full
);

	logic        inside_word_q;
	logic [5:0]  letter_pos_q;
	logic        still_equal_q;
	logic        prefix_open_q;
	logic [15:0] line_q;
	logic [31:0] page_q;

	logic        accept;
	logic        is_space;
	logic        is_letter;
	logic        is_newline;
	logic [15:0] lpp;
	logic [16:0] line_next;
	logic        page_wrap;
	logic [31:0] page_after_nl;
	logic [15:0] line_after_nl;
	logic        word_match;
	logic [7:0]  query_byte;
	logic        letter_miss;

	assign in_ready = ~ev_full;
	assign accept   = in_valid & in_ready;

	// Classify the byte
	assign is_space   = (text_byte == 8'h20) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));
	assign is_letter  = ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
	                    ((text_byte >= 8'h61) && (text_byte <= 8'h7A));
	assign is_newline = (text_byte == NEWLINE_BYTE);

	// Advance line and page on a newline
	assign lpp           = (cfg.lines_per_page < MIN_LINES_PER_PAGE) ? MIN_LINES_PER_PAGE
	                                                                 : cfg.lines_per_page;
	assign line_next     = {1'b0, line_q} + 17'd1;
	assign page_wrap     = is_newline && (line_next >= {1'b0, lpp});
	assign page_after_nl = page_wrap ? sat_inc(page_q) : page_q;
	assign line_after_nl = !is_newline ? line_q : (page_wrap ? 16'd0 : line_next[15:0]);

	// Compare the next prefix letter with the query
	assign query_byte  = cfg.query_chars[{letter_pos_q[4:0], 3'b000} +: 8];
	assign letter_miss = (letter_pos_q >= cfg.query_length) || letter_pos_q[5] ||
	                     (query_byte != text_byte);
	assign word_match  = still_equal_q && ({1'b0, cfg.query_length} <= 7'(QUERY_MAX)) &&
	                     (letter_pos_q == cfg.query_length);

	// Build the event for a finished word or end of text
	always_comb begin
		ev.is_match     = word_match & inside_word_q;
		ev.is_final     = end_of_text;
		ev.word_present = inside_word_q;
		ev.page_number  = 32'd0;
		ev_push         = 1'b0;
		if (end_of_text) begin
			ev_push        = accept;
			ev.page_number = inside_word_q ? page_q : 32'd0;
		end else if (is_space && inside_word_q) begin
			ev_push        = accept;
			ev.page_number = page_after_nl;
		end
	end

	// Update word and line state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_word_q <= 1'b0;
			letter_pos_q  <= 6'd0;
			still_equal_q <= 1'b1;
			prefix_open_q <= 1'b1;
			line_q        <= 16'd1;
			page_q        <= 32'd0;
		end else if (accept) begin
			if (end_of_text || is_space) begin
				inside_word_q <= 1'b0;
				letter_pos_q  <= 6'd0;
				still_equal_q <= 1'b1;
				prefix_open_q <= 1'b1;
			end else begin
				inside_word_q <= 1'b1;
				if (prefix_open_q) begin
					if (is_letter) begin
						if (letter_miss) begin
							still_equal_q <= 1'b0;
						end
						if (letter_pos_q < LETTER_POS_MAX) begin
							letter_pos_q <= letter_pos_q + 6'd1;
						end
					end else begin
						prefix_open_q <= 1'b0;
					end
				end
			end
			if (end_of_text) begin
				line_q <= 16'd1;
				page_q <= 32'd0;
			end else begin
				line_q <= line_after_nl;
				page_q <= page_after_nl;
			end
		end
	end

endmodule

>>> src/wqm_queue.sv
// Short event queue between front and back ends.
module wqm_queue
	import wqm_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  wqm_event_t push_data,
	output logic       full,
	input  logic       pop,
	output wqm_event_t pop_data,
	output logic       not_empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	wqm_event_t      entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Store pushed events
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> src/wqm_back.sv
// Back end: keeps the running totals and holds the result item for the output.
module wqm_back
	import wqm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_valid,
	input  wqm_event_t  ev,
	output logic        ev_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_match,
	output logic        is_final,
	output logic        word_present,
	output logic [31:0] page_number,
	output logic [31:0] words_seen,
	output logic [31:0] matches_seen
);

	logic        out_valid_q;
	logic [31:0] word_total_q;
	logic [31:0] match_total_q;
	logic [31:0] word_next;
	logic [31:0] match_next;
	logic        is_match_q;
	logic        is_final_q;
	logic        word_present_q;
	logic [31:0] page_q;

	// Take the next event when the output is free or being taken
	assign ev_pop     = ev_valid && (!out_valid_q || out_ready);
	assign word_next  = ev.word_present ? sat_inc(word_total_q) : word_total_q;
	assign match_next = ev.is_match ? sat_inc(match_total_q) : match_total_q;

	// Hold totals and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			word_total_q  <= 32'd0;
			match_total_q <= 32'd0;
		end else begin
			if (ev_pop) begin
				out_valid_q   <= 1'b1;
				word_total_q  <= word_next;
				match_total_q <= match_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (ev_pop) begin
			is_match_q     <= ev.is_match;
			is_final_q     <= ev.is_final;
			word_present_q <= ev.word_present;
			page_q         <= ev.page_number;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_match     = is_match_q;
	assign is_final     = is_final_q;
	assign word_present = word_present_q;
	assign page_number  = page_q;
	assign words_seen   = word_total_q;
	assign matches_seen = match_total_q;

endmodule

>>> src/word_query_matcher.sv
// Top level of the streaming whole-word query matcher.
//
//  Channel  Direction  Payload
//  s_*      in         tdata[7:0] text_byte; tuser[0] end_of_text
//  m_*      out        tdata page_number, words_seen, matches_seen;
//                      tuser is_match, is_final, word_present
//  APB      in/out     64-bit registers at 8*i: query_length, four query words,
//                      lines_per_page
//
// One input item per cycle is taken while the event queue has room; a result
// passes through the event queue and then the output register on its way out.
// The front end sets the rate: one byte each cycle through the classifier while the queue has room.
// Reset is asynchronous and clears all control state and the totals.
// A stalled output first fills the queue, then s_tready drops.
module word_query_matcher
	import wqm_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] page_number, [63:32] words_seen,
	                               // [95:64] matches_seen
	output logic [2:0]  m_tuser,   // [0] is_match, [1] is_final, [2] word_present
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	wqm_cfg_t   cfg;
	wqm_event_t push_ev;
	wqm_event_t pop_ev;
	logic       ev_push;
	logic       ev_full;
	logic       ev_pop;
	logic       ev_valid;

	wqm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wqm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.text_byte   (s_tdata),
		.end_of_text (s_tuser),
		.in_ready    (s_tready),
		.ev_push     (ev_push),
		.ev          (push_ev),
		.ev_full     (ev_full)
	);

	wqm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_data (push_ev),
		.full      (ev_full),
		.pop       (ev_pop),
		.pop_data  (pop_ev),
		.not_empty (ev_valid)
	);

	wqm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (ev_valid),
		.ev           (pop_ev),
		.ev_pop       (ev_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.is_match     (m_tuser[0]),
		.is_final     (m_tuser[1]),
		.word_present (m_tuser[2]),
		.page_number  (m_tdata[31:0]),
		.words_seen   (m_tdata[63:32]),
		.matches_seen (m_tdata[95:64])
	);

endmodule
